// ===== hw/rtl/grid_velocity_moment_deposit_defines.svh =====
// Assertion macros shared by the velocity moment deposit RTL.
`ifndef GRID_VELOCITY_MOMENT_DEPOSIT_DEFINES_SVH
`define GRID_VELOCITY_MOMENT_DEPOSIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define GVMD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define GVMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/gvmd_pkg.sv =====
// Types and constants of the grid velocity moment deposit block.
`default_nettype none

package gvmd_pkg;

  // Item operations carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_DEPOSIT = 2'd0,
    OP_READ    = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  // Configuration register indexes, taken from paddr[2].
  localparam logic REG_USED_ROWS = 1'b0;
  localparam logic REG_USED_COLS = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [6:0] USED_ROWS_RESET = 7'd64;
  localparam logic [7:0] USED_COLS_RESET = 8'd128;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_MUL,
    ST_ACC,
    ST_RESP,
    ST_CLEAR
  } state_t;

  // One grid cell, lowest field in the lowest bits.
  typedef struct packed {
    logic [31:0] particle_count;
    logic [63:0] sumsq_azimuthal;
    logic [63:0] sumsq_radial;
    logic [63:0] sumsq_axial;
    logic [63:0] sum_azimuthal;
    logic [63:0] sum_radial;
    logic [63:0] sum_axial;
  } cell_t;

  localparam int IN_W  = 104;
  localparam int OUT_W = $bits(cell_t);

endpackage

`default_nettype wire

// ===== hw/rtl/grid_velocity_moment_deposit.sv =====
// Grid velocity moment deposit: cell store, read-modify-write datapath and control.
//
// Channel | Direction | Contents
// s_*     | in        | tuser opcode; tdata row, column, three velocities, weight
// m_*     | out       | tdata seven cell sums of one read item
// APB     | in/out    | used_rows at 0x0, used_cols at 0x4
//
// A deposit is accepted, reads its cell, multiplies, then accumulates and writes back;
// one outside the grid or of zero weight ends after the cell read.
// A read is accepted, reads its cell, then waits for the output register to drain.
// A clear is accepted and then clears one cell per cycle, a rate set by the single
// write port of the store.
// After reset the store is swept to zero, one cell a cycle, over all EFF_ROWS*EFF_COLS
// cells (8192 by default, capped at 64 rows by 128 columns); no item is accepted meanwhile.
// A result waiting in the output register stalls only a later read item.
`default_nettype none

module grid_velocity_moment_deposit #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 128,
  parameter int VEL_BITS  = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // input items
  input  wire logic                       s_tvalid,
  output      logic                       s_tready,
  // s_tdata: cell_row[5:0], cell_col[12:6], vel_axial[36:13], vel_radial[60:37],
  //          vel_azimuthal[84:61], weight[100:85], zero[103:101]
  input  wire logic [gvmd_pkg::IN_W-1:0]  s_tdata,
  // s_tuser: opcode[1:0]
  input  wire logic [1:0]                 s_tuser,
  // result items
  output      logic                       m_tvalid,
  input  wire logic                       m_tready,
  // m_tdata: sum_axial[63:0], sum_radial[127:64], sum_azimuthal[191:128],
  //          sumsq_axial[255:192], sumsq_radial[319:256], sumsq_azimuthal[383:320],
  //          particle_count[415:384]
  output      logic [gvmd_pkg::OUT_W-1:0] m_tdata,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      logic                       pready
);

  import gvmd_pkg::*;

  // Only rows and columns reachable by the index fields are stored.
  localparam int EFF_ROWS = (GRID_ROWS < 64) ? GRID_ROWS : 64;
  localparam int EFF_COLS = (GRID_COLS < 128) ? GRID_COLS : 128;
  localparam int DEPTH    = EFF_ROWS * EFF_COLS;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW       = (EFF_ROWS > 1) ? $clog2(EFF_ROWS) : 1;
  localparam int CW       = (EFF_COLS > 1) ? $clog2(EFF_COLS) : 1;
  localparam int LIN_W    = VEL_BITS + 17;
  localparam int SQ_W     = 2 * VEL_BITS;
  localparam int WSQ_W    = SQ_W + 16;

  // Saturating signed 64-bit add.
  function automatic logic [63:0] sat_add_s(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // Saturating unsigned 64-bit add.
  function automatic logic [63:0] sat_add_u(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  // Saturating count update.
  function automatic logic [31:0] sat_cnt(input logic [31:0] a, input logic [15:0] w);
    logic [32:0] s;
    s = {1'b0, a} + 33'(w);
    return s[32] ? {32{1'b1}} : s[31:0];
  endfunction

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [6:0] used_rows;
  logic [7:0] used_cols;
  logic       cfg_wr;
  logic [7:0] nr8;
  logic [7:0] nc8;

  // Item registers.
  op_t                       item_op;
  logic                      item_inside;
  logic [AW-1:0]             item_addr;
  logic [15:0]               item_weight;
  logic signed [VEL_BITS-1:0] item_vel [3];

  // Pipeline registers.
  logic signed [LIN_W-1:0] lin [3];
  logic [SQ_W-1:0]         sq [3];
  logic [63:0]             lin64 [3];
  logic [63:0]             wsq [3];
  logic [VEL_BITS-1:0]     mag [3];

  // Store and its ports.
  cell_t         cells [DEPTH];
  cell_t         rdata;
  cell_t         wdata;
  cell_t         acc_cell;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;

  // Sweep counters.
  logic [AW-1:0] init_addr;
  logic [RW-1:0] clr_row;
  logic [CW-1:0] clr_col;
  logic          clr_last_col;
  logic          clr_last_row;

  // Output register.
  cell_t out_cell;
  logic  out_load;
  logic  out_free;

  // Decoded input item.
  logic          s_accept;
  op_t           s_op;
  logic [5:0]    s_row;
  logic [6:0]    s_col;
  logic          s_inside;
  logic [AW-1:0] s_addr;
  logic [31:0]   s_vel_raw [3];

  assign s_accept = s_tvalid && s_tready;
  assign s_op     = op_t'(s_tuser);
  assign s_row    = s_tdata[5:0];
  assign s_col    = s_tdata[12:6];
  assign s_vel_raw[0] = {8'd0, s_tdata[36:13]};
  assign s_vel_raw[1] = {8'd0, s_tdata[60:37]};
  assign s_vel_raw[2] = {8'd0, s_tdata[84:61]};
  assign s_inside = (32'(s_row) < 32'(GRID_ROWS)) && (32'(s_col) < 32'(GRID_COLS));
  assign s_addr   = s_inside ? AW'(32'(s_row) * 32'(EFF_COLS) + 32'(s_col)) : '0;

  // Clear region bounds.
  assign nr8 = (32'(used_rows) < 32'(EFF_ROWS)) ? 8'(used_rows) : 8'(EFF_ROWS);
  assign nc8 = (32'(used_cols) < 32'(EFF_COLS)) ? 8'(used_cols) : 8'(EFF_COLS);
  assign clr_last_col = (8'(clr_col) + 8'd1 == nc8);
  assign clr_last_row = (8'(clr_row) + 8'd1 == nr8);

  // Configuration port: writes on the access phase, reads are combinational.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_USED_COLS) ? {24'd0, used_cols} : {25'd0, used_rows};

  always_ff @(posedge clk) begin
    if (rst) begin
      used_rows <= USED_ROWS_RESET;
      used_cols <= USED_COLS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_USED_ROWS) begin
        used_rows <= pwdata[6:0];
      end else begin
        used_cols <= pwdata[7:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (init_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (s_op)
            OP_DEPOSIT, OP_READ: state_next = ST_LOOK;
            OP_CLEAR:            state_next = (nr8 != 8'd0 && nc8 != 8'd0) ? ST_CLEAR
                                                                            : ST_IDLE;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOOK: begin
        if (item_op == OP_READ) begin
          state_next = ST_RESP;
        end else if (!item_inside || item_weight == 16'd0) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_ACC;
      ST_ACC:   state_next = ST_IDLE;
      ST_RESP: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_last_col && clr_last_row) state_next = ST_IDLE;
      end
      default:  state_next = ST_INIT;
    endcase
  end

  // Accumulated cell, from the stored cell and the registered products.
  always_comb begin
    acc_cell.sum_axial       = sat_add_s(rdata.sum_axial, lin64[0]);
    acc_cell.sum_radial      = sat_add_s(rdata.sum_radial, lin64[1]);
    acc_cell.sum_azimuthal   = sat_add_s(rdata.sum_azimuthal, lin64[2]);
    acc_cell.sumsq_axial     = sat_add_u(rdata.sumsq_axial, wsq[0]);
    acc_cell.sumsq_radial    = sat_add_u(rdata.sumsq_radial, wsq[1]);
    acc_cell.sumsq_azimuthal = sat_add_u(rdata.sumsq_azimuthal, wsq[2]);
    acc_cell.particle_count  = sat_cnt(rdata.particle_count, item_weight);
  end

  // Outputs of the controller.
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = item_addr;
    wdata     = '0;
    out_load  = 1'b0;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_addr;
      end
      ST_IDLE:  s_tready = 1'b1;
      ST_LOOK:  mem_re = 1'b1;
      ST_MUL:   ;
      ST_ACC: begin
        mem_we = 1'b1;
        wdata  = acc_cell;
      end
      ST_RESP:  out_load = out_free;
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(32'(clr_row) * 32'(EFF_COLS) + 32'(clr_col));
      end
      default:  ;
    endcase
  end

  // Controller registers and sweep counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      init_addr <= '0;
      clr_row   <= '0;
      clr_col   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT) init_addr <= init_addr + AW'(1);
      if (s_accept) begin
        clr_row <= '0;
        clr_col <= '0;
      end else if (state == ST_CLEAR) begin
        if (clr_last_col) begin
          clr_col <= '0;
          clr_row <= clr_row + RW'(1);
        end else begin
          clr_col <= clr_col + CW'(1);
        end
      end
    end
  end

  // Item capture; velocities are sign-extended from bit VEL_BITS-1.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      item_op     <= s_op;
      item_inside <= s_inside;
      item_addr   <= s_addr;
      item_weight <= s_tdata[100:85];
      for (int i = 0; i < 3; i++) begin
        item_vel[i] <= $signed(s_vel_raw[i][VEL_BITS-1:0]);
      end
    end
  end

  // Magnitudes for the squares.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = item_vel[i][VEL_BITS-1] ? (~item_vel[i] + VEL_BITS'(1)) : item_vel[i];
    end
  end

  // First multiply stage: weight times velocity, velocity squared.
  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      for (int i = 0; i < 3; i++) begin
        lin[i] <= item_vel[i] * $signed({1'b0, item_weight});
        sq[i]  <= mag[i] * mag[i];
      end
    end
  end

  // Second multiply stage: weight times square, clamped to 64 bits.
  always_ff @(posedge clk) begin
    logic [WSQ_W-1:0] wsq_full;
    logic [79:0]      wsq_ext;
    if (state == ST_MUL) begin
      for (int i = 0; i < 3; i++) begin
        wsq_full = sq[i] * item_weight;
        wsq_ext  = 80'(wsq_full);
        wsq[i]   <= (wsq_ext[79:64] != 16'd0) ? {64{1'b1}} : wsq_ext[63:0];
        lin64[i] <= 64'(lin[i]);
      end
    end
  end

  // Cell store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) cells[mem_waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata <= cells[item_addr];
  end

  // Output register; a cell outside the grid reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_cell <= item_inside ? rdata : '0;
  end

  assign m_tdata = out_cell;

`include "grid_velocity_moment_deposit_defines.svh"

  `GVMD_ASSERT_SAME(a_no_result_in_init, state == ST_INIT, !m_tvalid, "result during reset sweep")
  `GVMD_ASSERT_SAME(a_load_when_free, out_load, !m_tvalid || m_tready, "waiting result overwritten")
  `GVMD_ASSERT_SAME(a_acc_inside, state == ST_ACC, item_inside && item_weight != 16'd0, "write-back of a skipped deposit")
  `GVMD_ASSERT_NEXT(a_read_to_resp, state == ST_LOOK && item_op == OP_READ, state == ST_RESP, "read lost its response state")
  `GVMD_ASSERT_SAME(a_clear_in_region, state == ST_CLEAR, 8'(clr_row) < nr8 && 8'(clr_col) < nc8, "clear sweep left the region")

endmodule

`default_nettype wire
